>>> rtl/core/stmh_pkg.sv
// ----------------------------------------------------------------------------
// stmh_pkg
// Shared types and constants of the sleep timer min-heap.
// ----------------------------------------------------------------------------
package stmh_pkg;

	localparam int WAKE_W = 32;
	localparam int TAG_W = 8;
	localparam int SECS_W = 16;
	localparam int TPS_W = 10;
	localparam int PROD_W = SECS_W - 1 + TPS_W;
	localparam logic [TPS_W-1:0] TPS_RESET = 10'd10;

	localparam int MAX_WAKES = 16;
	localparam int WCNT_W = $clog2(MAX_WAKES + 1);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic OP_SLEEP = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [1:0] {
		RES_ACCEPT = 2'd0,
		RES_REJ_NEG = 2'd1,
		RES_REJ_FULL = 2'd2,
		RES_WAKE = 2'd3
	} res_kind_t;

	typedef enum logic [1:0] {
		CMD_SLEEP = 2'd0,
		CMD_NEG = 2'd1,
		CMD_TICK = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [PROD_W-1:0] prod;
		logic [TAG_W-1:0] tag;
	} cmd_t;

	typedef struct packed {
		logic [WAKE_W-1:0] wake;
		logic [TAG_W-1:0] tag;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_RESULT,
		ST_UP,
		ST_UP_CMP,
		ST_TCHK,
		ST_TCHK_CMP,
		ST_POP_RD,
		ST_POP_LAST,
		ST_DN,
		ST_DN_L,
		ST_DN_R
	} heap_state_t;

endpackage

>>> rtl/core/stmh_front.sv
// ----------------------------------------------------------------------------
// stmh_front
// Accepts requests, classifies them and scales the sleep duration to ticks.
// ----------------------------------------------------------------------------
module stmh_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [stmh_pkg::TPS_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic signed [stmh_pkg::SECS_W-1:0] sleep_seconds,
	input  logic [stmh_pkg::TAG_W-1:0]    sleeper_tag,
	output logic                          q_valid,
	input  logic                          q_ready,
	output stmh_pkg::cmd_t                q_data
);

	logic [stmh_pkg::TPS_W-1:0] tps_q;
	logic valid_s1;
	logic op_s1;
	logic [stmh_pkg::SECS_W-1:0] secs_s1;
	logic [stmh_pkg::TAG_W-1:0] tag_s1;

	assign cfg_ready = 1'b1;
	assign in_ready = !valid_s1 || q_ready;
	assign q_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= stmh_pkg::TPS_RESET;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_valid) begin
				tps_q <= cfg_data;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1 <= op;
			secs_s1 <= sleep_seconds;
			tag_s1 <= sleeper_tag;
		end
	end

	always_comb begin
		if (op_s1 == stmh_pkg::OP_TICK) begin
			q_data.kind = stmh_pkg::CMD_TICK;
		end else if (secs_s1[stmh_pkg::SECS_W-1]) begin
			q_data.kind = stmh_pkg::CMD_NEG;
		end else begin
			q_data.kind = stmh_pkg::CMD_SLEEP;
		end
		q_data.prod = stmh_pkg::PROD_W'(secs_s1[stmh_pkg::SECS_W-2:0])
			* stmh_pkg::PROD_W'(tps_q);
		q_data.tag = tag_s1;
	end

endmodule

>>> rtl/core/stmh_queue.sv
// ----------------------------------------------------------------------------
// stmh_queue
// Short command queue between the front end and the heap engine.
// ----------------------------------------------------------------------------
module stmh_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  stmh_pkg::cmd_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output stmh_pkg::cmd_t pop_data
);

	stmh_pkg::cmd_t slots_q [stmh_pkg::QUEUE_DEPTH];
	logic [stmh_pkg::QPTR_W-1:0] wptr_q;
	logic [stmh_pkg::QPTR_W-1:0] rptr_q;
	logic [stmh_pkg::QCNT_W-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign push_ready = cnt_q != stmh_pkg::QCNT_W'(stmh_pkg::QUEUE_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_data = slots_q[rptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == stmh_pkg::QPTR_W'(stmh_pkg::QUEUE_DEPTH - 1))
					? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == stmh_pkg::QPTR_W'(stmh_pkg::QUEUE_DEPTH - 1))
					? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/core/stmh_heap.sv
// ----------------------------------------------------------------------------
// stmh_heap
// Heap engine: keeps the tick counter and the min-heap, runs insert with
// sift-up and pop with sift-down over a single-port-read memory, and drives
// the result register.
// ----------------------------------------------------------------------------
module stmh_heap #(
	parameter int CAPACITY = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	output logic                       q_ready,
	input  stmh_pkg::cmd_t             q_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 result_kind,
	output logic [stmh_pkg::TAG_W-1:0] woken_tag,
	output logic                       last
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = CW + 1;

	stmh_pkg::heap_state_t state_q, state_d;

	stmh_pkg::entry_t mem [CAPACITY];
	stmh_pkg::entry_t rd_data_q;
	logic rd_en;
	logic [IW-1:0] rd_addr;
	logic wr_en;
	logic [IW-1:0] wr_addr;
	stmh_pkg::entry_t wr_data;

	logic [CW-1:0] count_q;
	logic [stmh_pkg::WAKE_W-1:0] tick_q;
	logic [stmh_pkg::WCNT_W-1:0] n_q;
	logic pend_valid_q;
	logic out_valid_q;

	stmh_pkg::cmd_t cmd_q;
	stmh_pkg::entry_t item_q;
	stmh_pkg::entry_t left_q;
	logic [IW-1:0] pos_q;
	logic [stmh_pkg::TAG_W-1:0] pend_tag_q;
	stmh_pkg::res_kind_t res_kind_q;
	stmh_pkg::res_kind_t out_kind_q;
	logic [stmh_pkg::TAG_W-1:0] out_tag_q;
	logic out_last_q;

	logic out_free;
	logic out_load;
	stmh_pkg::res_kind_t out_kind_d;
	logic [stmh_pkg::TAG_W-1:0] out_tag_d;
	logic out_last_d;

	logic heap_full;
	logic [stmh_pkg::WAKE_W:0] wake_sum;
	logic [stmh_pkg::WAKE_W-1:0] wake_sat;
	logic [IW-1:0] parent;
	logic [XW-1:0] lidx;
	logic [XW-1:0] ridx;
	logic has_r;
	logic due;
	logic up_move;
	logic sel_l1;
	logic sel_l;
	logic sel_r;
	logic [stmh_pkg::WAKE_W-1:0] min_lw;

	assign out_free = !out_valid_q || out_ready;
	assign q_ready = state_q == stmh_pkg::ST_IDLE;
	assign heap_full = count_q == CW'(CAPACITY);
	assign wake_sum = {1'b0, tick_q} + (stmh_pkg::WAKE_W + 1)'(cmd_q.prod);
	assign wake_sat = wake_sum[stmh_pkg::WAKE_W] ? '1 : wake_sum[stmh_pkg::WAKE_W-1:0];
	assign parent = (pos_q - IW'(1)) >> 1;
	assign lidx = XW'({pos_q, 1'b1});
	assign ridx = lidx + XW'(1);
	assign has_r = ridx < XW'(count_q);
	assign due = (count_q != '0) && (rd_data_q.wake <= tick_q)
		&& (n_q != stmh_pkg::WCNT_W'(stmh_pkg::MAX_WAKES));
	assign up_move = rd_data_q.wake > item_q.wake;
	assign sel_l1 = rd_data_q.wake < item_q.wake;
	assign sel_l = left_q.wake < item_q.wake;
	assign min_lw = sel_l ? left_q.wake : item_q.wake;
	assign sel_r = rd_data_q.wake < min_lw;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stmh_pkg::ST_IDLE: begin
				if (q_valid) begin
					state_d = stmh_pkg::ST_DISPATCH;
				end
			end
			stmh_pkg::ST_DISPATCH: begin
				unique case (cmd_q.kind)
					stmh_pkg::CMD_TICK: state_d = stmh_pkg::ST_TCHK;
					stmh_pkg::CMD_SLEEP: begin
						state_d = heap_full ? stmh_pkg::ST_RESULT : stmh_pkg::ST_UP;
					end
					default: state_d = stmh_pkg::ST_RESULT;
				endcase
			end
			stmh_pkg::ST_RESULT: begin
				if (out_free) begin
					state_d = stmh_pkg::ST_IDLE;
				end
			end
			stmh_pkg::ST_UP: begin
				state_d = (pos_q == '0) ? stmh_pkg::ST_RESULT : stmh_pkg::ST_UP_CMP;
			end
			stmh_pkg::ST_UP_CMP: begin
				state_d = up_move ? stmh_pkg::ST_UP : stmh_pkg::ST_RESULT;
			end
			stmh_pkg::ST_TCHK: state_d = stmh_pkg::ST_TCHK_CMP;
			stmh_pkg::ST_TCHK_CMP: begin
				if (!pend_valid_q || out_free) begin
					state_d = due ? stmh_pkg::ST_POP_RD : stmh_pkg::ST_IDLE;
				end
			end
			stmh_pkg::ST_POP_RD: begin
				state_d = (count_q == '0) ? stmh_pkg::ST_TCHK : stmh_pkg::ST_POP_LAST;
			end
			stmh_pkg::ST_POP_LAST: state_d = stmh_pkg::ST_DN;
			stmh_pkg::ST_DN: begin
				state_d = (lidx >= XW'(count_q)) ? stmh_pkg::ST_TCHK : stmh_pkg::ST_DN_L;
			end
			stmh_pkg::ST_DN_L: begin
				if (has_r) begin
					state_d = stmh_pkg::ST_DN_R;
				end else begin
					state_d = sel_l1 ? stmh_pkg::ST_DN : stmh_pkg::ST_TCHK;
				end
			end
			stmh_pkg::ST_DN_R: begin
				state_d = (sel_r || sel_l) ? stmh_pkg::ST_DN : stmh_pkg::ST_TCHK;
			end
			default: state_d = stmh_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		rd_en = 1'b0;
		rd_addr = '0;
		wr_en = 1'b0;
		wr_addr = pos_q;
		wr_data = item_q;
		out_load = 1'b0;
		out_kind_d = res_kind_q;
		out_tag_d = cmd_q.tag;
		out_last_d = 1'b1;
		unique case (state_q)
			stmh_pkg::ST_RESULT: begin
				out_load = out_free;
			end
			stmh_pkg::ST_UP: begin
				if (pos_q == '0) begin
					wr_en = 1'b1;
				end else begin
					rd_en = 1'b1;
					rd_addr = parent;
				end
			end
			stmh_pkg::ST_UP_CMP: begin
				wr_en = 1'b1;
				if (up_move) begin
					wr_data = rd_data_q;
				end
			end
			stmh_pkg::ST_TCHK: begin
				rd_en = 1'b1;
			end
			stmh_pkg::ST_TCHK_CMP: begin
				out_load = pend_valid_q && out_free;
				out_kind_d = stmh_pkg::RES_WAKE;
				out_tag_d = pend_tag_q;
				out_last_d = !due;
			end
			stmh_pkg::ST_POP_RD: begin
				rd_en = count_q != '0;
				rd_addr = count_q[IW-1:0];
			end
			stmh_pkg::ST_DN: begin
				if (lidx >= XW'(count_q)) begin
					wr_en = 1'b1;
				end else begin
					rd_en = 1'b1;
					rd_addr = lidx[IW-1:0];
				end
			end
			stmh_pkg::ST_DN_L: begin
				if (has_r) begin
					rd_en = 1'b1;
					rd_addr = ridx[IW-1:0];
				end else begin
					wr_en = 1'b1;
					if (sel_l1) begin
						wr_data = rd_data_q;
					end
				end
			end
			stmh_pkg::ST_DN_R: begin
				wr_en = 1'b1;
				if (sel_r) begin
					wr_data = rd_data_q;
				end else if (sel_l) begin
					wr_data = left_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stmh_pkg::ST_IDLE;
			count_q <= '0;
			tick_q <= '0;
			n_q <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == stmh_pkg::ST_DISPATCH) begin
				if (cmd_q.kind == stmh_pkg::CMD_TICK) begin
					tick_q <= tick_q + 1'b1;
					n_q <= '0;
					pend_valid_q <= 1'b0;
				end else if (cmd_q.kind == stmh_pkg::CMD_SLEEP && !heap_full) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (state_q == stmh_pkg::ST_TCHK_CMP && (!pend_valid_q || out_free)) begin
				pend_valid_q <= due;
				if (due) begin
					n_q <= n_q + 1'b1;
					count_q <= count_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q <= out_kind_d;
			out_tag_q <= out_tag_d;
			out_last_q <= out_last_d;
		end
		unique case (state_q)
			stmh_pkg::ST_IDLE: begin
				cmd_q <= q_data;
			end
			stmh_pkg::ST_DISPATCH: begin
				item_q <= '{wake: wake_sat, tag: cmd_q.tag};
				pos_q <= count_q[IW-1:0];
				if (cmd_q.kind == stmh_pkg::CMD_NEG) begin
					res_kind_q <= stmh_pkg::RES_REJ_NEG;
				end else if (heap_full) begin
					res_kind_q <= stmh_pkg::RES_REJ_FULL;
				end else begin
					res_kind_q <= stmh_pkg::RES_ACCEPT;
				end
			end
			stmh_pkg::ST_UP_CMP: begin
				if (up_move) begin
					pos_q <= parent;
				end
			end
			stmh_pkg::ST_TCHK_CMP: begin
				if (due && (!pend_valid_q || out_free)) begin
					pend_tag_q <= rd_data_q.tag;
				end
			end
			stmh_pkg::ST_POP_LAST: begin
				item_q <= rd_data_q;
				pos_q <= '0;
			end
			stmh_pkg::ST_DN_L: begin
				left_q <= rd_data_q;
				if (!has_r && sel_l1) begin
					pos_q <= lidx[IW-1:0];
				end
			end
			stmh_pkg::ST_DN_R: begin
				if (sel_r) begin
					pos_q <= ridx[IW-1:0];
				end else if (sel_l) begin
					pos_q <= lidx[IW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign result_kind = out_kind_q;
	assign woken_tag = out_tag_q;
	assign last = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("heap count exceeds capacity");

	a_wake_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= stmh_pkg::WCNT_W'(stmh_pkg::MAX_WAKES))
		else $error("too many wakes for one tick");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while held");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == stmh_pkg::ST_IDLE) |-> !pend_valid_q)
		else $error("pending wake left behind at idle");

	a_tick_source: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(tick_q) |-> $past(state_q == stmh_pkg::ST_DISPATCH))
		else $error("tick counter moved outside dispatch");

endmodule

>>> rtl/core/sleep_timer_min_heap.sv
// ----------------------------------------------------------------------------
// sleep_timer_min_heap
// Timer queue of sleepers kept as a binary min-heap on wake time.
// ----------------------------------------------------------------------------
// Requests are taken one at a time by the heap engine, which reads its heap
// memory through one registered read port. A sleep request climbs the heap
// one level at a time in its sift-up; a rejected request skips it. A tick
// wakes each due sleeper in turn (at most 16 per tick) and sifts the heap
// down after each one. The front end and a four-entry command queue keep
// taking requests while the engine is busy, and the result register lets the
// engine finish a result while the previous one is still waiting.
module sleep_timer_min_heap #(
	parameter int CAPACITY = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [stmh_pkg::TPS_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                op,
	input  logic signed [stmh_pkg::SECS_W-1:0]  sleep_seconds,
	input  logic [stmh_pkg::TAG_W-1:0]          sleeper_tag,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          result_kind,
	output logic [stmh_pkg::TAG_W-1:0]          woken_tag,
	output logic                                last
);

	logic fq_valid;
	logic fq_ready;
	stmh_pkg::cmd_t fq_data;
	logic qh_valid;
	logic qh_ready;
	stmh_pkg::cmd_t qh_data;

	stmh_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.sleep_seconds (sleep_seconds),
		.sleeper_tag   (sleeper_tag),
		.q_valid       (fq_valid),
		.q_ready       (fq_ready),
		.q_data        (fq_data)
	);

	stmh_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_data),
		.pop_valid  (qh_valid),
		.pop_ready  (qh_ready),
		.pop_data   (qh_data)
	);

	stmh_heap #(
		.CAPACITY (CAPACITY)
	) u_heap (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (qh_valid),
		.q_ready     (qh_ready),
		.q_data      (qh_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_kind (result_kind),
		.woken_tag   (woken_tag),
		.last        (last)
	);

endmodule
